[sv/tbs_pkg.sv]
// ----------------------------------------------------------------------------
// tbs_pkg
// shared types and constants for the token bucket shaper
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int RATE_W   = 24;
    localparam int TOKEN_W  = 32;
    localparam int LIMIT_W  = 7;
    localparam int BYTES_W  = 16;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0]  RATE_RESET   = 24'd1000;
    localparam logic [TOKEN_W-1:0] DEPTH_RESET  = 32'd100000;
    localparam logic [LIMIT_W-1:0] QLIMIT_RESET = 7'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_FORWARD  = 3'd1,
        ACT_QUEUED   = 3'd2,
        ACT_DROPPED  = 3'd3,
        ACT_RELEASED = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE   = 2'd0,
        CFG_DEPTH  = 2'd1,
        CFG_QLIMIT = 2'd2
    } t_cfg_idx;

endpackage

[sv/token_bucket_shaper_unit.sv]
// ----------------------------------------------------------------------------
// token_bucket_shaper_unit
// token bucket shaper with a holding queue kept in a dual-read memory
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries one beat per step: a
//   packet arrival (i_cmd 0, size and tag) or a tick (i_cmd 1).
//   output channel (o_out_valid / i_out_stall) returns exactly one beat per
//   input beat, in order: action, tag, size, queue fill and tokens after it.
//   configuration writes (rate, bucket depth, queue limit) go over the
//   i_cfg_valid / o_cfg_ready channel, which is always ready.
//   an accepted beat reads the queue memory into the memory stage, and its
//   result is registered in the output register when that stage moves on.
//   throughput: one beat per cycle unless stalled; the memory is read at
//   the head and the slot after it on every accept, so a release in the
//   previous step never stalls the next; a fresh queue write is forwarded.
//   when the receiver stalls, the result holds and one more beat is taken
//   into the memory stage, then o_in_stall rises.
//   reset empties the queue, zeroes the bucket and reloads the register
//   defaults; the bucket fills to its depth at the first arrival.
// ----------------------------------------------------------------------------
module token_bucket_shaper_unit #(
    parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [tbs_pkg::BYTES_W-1:0]       i_pkt_bytes,
    input  logic [tbs_pkg::TAG_W-1:0]         i_pkt_tag,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tbs_pkg::ACTION_W-1:0]      o_action,
    output logic [tbs_pkg::TAG_W-1:0]         o_out_tag,
    output logic [tbs_pkg::BYTES_W-1:0]       o_out_bytes,
    output logic [tbs_pkg::COUNT_W-1:0]       o_queued_count,
    output logic [tbs_pkg::TOKEN_W-1:0]       o_tokens_now,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENTRY_W = tbs_pkg::BYTES_W + tbs_pkg::TAG_W;
    localparam logic [31:0] DEPTH_32 = 32'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    // configuration registers
    logic [tbs_pkg::RATE_W-1:0]  r_rate;
    logic [tbs_pkg::TOKEN_W-1:0] r_depth;
    logic [tbs_pkg::LIMIT_W-1:0] r_qlimit;

    // bucket and queue control state
    logic [tbs_pkg::TOKEN_W-1:0] r_tokens, n_tokens;
    logic                        r_started;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [tbs_pkg::COUNT_W-1:0] r_count, n_count;

    // memory stage
    logic                        r_s1_valid;
    logic                        r_s1_cmd;
    logic [tbs_pkg::BYTES_W-1:0] r_s1_bytes;
    logic [tbs_pkg::TAG_W-1:0]   r_s1_tag;
    logic [ENTRY_W-1:0]          r_rd_head;
    logic [ENTRY_W-1:0]          r_rd_next;
    logic                        r_adv;
    logic                        r_wfw;
    logic [PTR_W-1:0]            r_waddr;
    logic [ENTRY_W-1:0]          r_wdata;

    logic [ENTRY_W-1:0]          mem [QUEUE_DEPTH];

    // output register
    logic                        r_out_valid;
    tbs_pkg::t_action            r_action, n_action;
    logic [tbs_pkg::TAG_W-1:0]   r_out_tag, n_out_tag;
    logic [tbs_pkg::BYTES_W-1:0] r_out_bytes, n_out_bytes;

    logic                        in_fire;
    logic                        s1_go;
    logic [PTR_W-1:0]            head_nx;
    logic [ENTRY_W-1:0]          head_entry;
    logic [tbs_pkg::BYTES_W-1:0] head_bytes;
    logic [tbs_pkg::TAG_W-1:0]   head_tag;
    logic [tbs_pkg::TOKEN_W:0]   tick_sum;
    logic [tbs_pkg::TOKEN_W-1:0] tick_capped;
    logic [tbs_pkg::TOKEN_W-1:0] head_need;
    logic [tbs_pkg::TOKEN_W-1:0] arr_need;
    logic [tbs_pkg::TOKEN_W-1:0] arr_base;
    logic [tbs_pkg::COUNT_W-1:0] limit_eff;
    logic                        do_release;
    logic                        do_queue;

    assign o_cfg_ready = 1'b1;

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign head_nx = (r_head == LAST_SLOT) ? '0 : r_head + PTR_W'(1);

    // head entry: pick the slot that is head now, forward a write made
    // while the read was in flight
    always_comb begin
        head_entry = r_adv ? r_rd_next : r_rd_head;
        if (r_wfw && (r_waddr == r_head)) begin
            head_entry = r_wdata;
        end
    end
    assign head_bytes = head_entry[ENTRY_W-1 -: tbs_pkg::BYTES_W];
    assign head_tag   = head_entry[tbs_pkg::TAG_W-1:0];

    assign tick_sum    = {1'b0, r_tokens} + (tbs_pkg::TOKEN_W+1)'(r_rate);
    assign tick_capped = (tick_sum > {1'b0, r_depth}) ? r_depth
                                                      : tick_sum[tbs_pkg::TOKEN_W-1:0];
    assign head_need   = {13'b0, head_bytes, 3'b000};
    assign arr_need    = {13'b0, r_s1_bytes, 3'b000};
    assign arr_base    = r_started ? r_tokens : r_depth;
    assign limit_eff   = ({25'b0, r_qlimit} > DEPTH_32) ? tbs_pkg::COUNT_W'(QUEUE_DEPTH)
                                                        : r_qlimit;

    always_comb begin
        n_tokens    = r_tokens;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_action    = tbs_pkg::ACT_NONE;
        n_out_tag   = '0;
        n_out_bytes = '0;
        do_release  = 1'b0;
        do_queue    = 1'b0;
        if (r_s1_cmd) begin
            n_tokens = tick_capped;
            if ((r_count != '0) && (tick_capped >= head_need)) begin
                do_release  = 1'b1;
                n_tokens    = tick_capped - head_need;
                n_head      = head_nx;
                n_count     = r_count - tbs_pkg::COUNT_W'(1);
                n_action    = tbs_pkg::ACT_RELEASED;
                n_out_tag   = head_tag;
                n_out_bytes = head_bytes;
            end
        end else begin
            n_tokens    = arr_base;
            n_out_tag   = r_s1_tag;
            n_out_bytes = r_s1_bytes;
            if ((r_count == '0) && (arr_base >= arr_need)) begin
                n_action = tbs_pkg::ACT_FORWARD;
                n_tokens = arr_base - arr_need;
            end else if (r_count < limit_eff) begin
                do_queue = 1'b1;
                n_action = tbs_pkg::ACT_QUEUED;
                n_tail   = (r_tail == LAST_SLOT) ? '0 : r_tail + PTR_W'(1);
                n_count  = r_count + tbs_pkg::COUNT_W'(1);
            end else begin
                n_action = tbs_pkg::ACT_DROPPED;
            end
        end
    end

    // queue memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (s1_go && do_queue) begin
            mem[r_tail] <= {r_s1_bytes, r_s1_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_head <= mem[r_head];
            r_rd_next <= mem[head_nx];
            r_waddr   <= r_tail;
            r_wdata   <= {r_s1_bytes, r_s1_tag};
            r_s1_cmd  <= i_cmd;
            r_s1_bytes <= i_pkt_bytes;
            r_s1_tag  <= i_pkt_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= tbs_pkg::RATE_RESET;
            r_depth     <= tbs_pkg::DEPTH_RESET;
            r_qlimit    <= tbs_pkg::QLIMIT_RESET;
            r_tokens    <= '0;
            r_started   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_adv       <= 1'b0;
            r_wfw       <= 1'b0;
            r_out_valid <= 1'b0;
            r_action    <= tbs_pkg::ACT_NONE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tbs_pkg::CFG_RATE:   r_rate   <= i_cfg_data[tbs_pkg::RATE_W-1:0];
                    tbs_pkg::CFG_DEPTH:  r_depth  <= i_cfg_data[tbs_pkg::TOKEN_W-1:0];
                    tbs_pkg::CFG_QLIMIT: r_qlimit <= i_cfg_data[tbs_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_adv      <= s1_go && do_release;
                r_wfw      <= s1_go && do_queue;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_tokens    <= n_tokens;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_action    <= n_action;
                r_out_valid <= 1'b1;
                if (!r_s1_cmd) begin
                    r_started <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_tag   <= n_out_tag;
            r_out_bytes <= n_out_bytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_out_tag      = r_out_tag;
    assign o_out_bytes    = r_out_bytes;
    assign o_queued_count = r_count;
    assign o_tokens_now   = r_tokens;

    // queue fill moves by at most one entry per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == $past(r_count) + tbs_pkg::COUNT_W'(1)) ||
                           (r_count == $past(r_count) - tbs_pkg::COUNT_W'(1)))
        else $error("queue fill jumped");

    // fill never exceeds the storage
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {25'b0, r_count} <= DEPTH_32)
        else $error("queue fill above storage depth");

    // a forwarded packet only passes an empty queue
    a_fwd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_action == tbs_pkg::ACT_FORWARD)) |-> (r_count == '0))
        else $error("forward with packets waiting");

    // an empty fill means tail and head point at the same slot
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with pointers apart");

endmodule
